FILE: sv/sap_pkg.sv
`timescale 1ns / 1ps

package sap_pkg;

    // Pool geometry
    localparam int POOL_PAGES   = 16;
    localparam int PAGE_W       = 4;
    localparam int PAGES_CNT_W  = 5;
    localparam int SLOT_W       = 9;
    localparam int LINK_W       = 10;
    localparam int CNT_W        = 10;
    localparam int SIZE_W       = 12;
    localparam int DIV_W        = 12;
    localparam int PROD_W       = 21;
    localparam int RAM_DEPTH    = 8192;
    localparam int RAM_AW       = 13;
    localparam int HEADER_BYTES = 12;
    localparam int PAGE_PAYLOAD = 4084;

    // Result status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_NULL_FREE = 2'd2;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd3;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OBJECT_SIZE = 1'b0;
    localparam logic CFG_POOL_FIRST  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NWAIT,
        ST_DECODE,
        ST_FWAIT,
        ST_CREATE,
        ST_POP_RD,
        ST_POP_UPD,
        ST_POP_ADDR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_start_n;
        logic div_start_free;
        logic load_n;
        logic sel_found;
        logic start_create;
        logic create_step;
        logic create_finish;
        logic free_commit;
        logic pop_read;
        logic pop_update;
        logic pop_addr;
        logic set_exhausted;
        logic set_null;
        logic set_outside;
        logic set_done_zero;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic dirty;
        logic op_free;
        logic any_found;
        logic pool_full;
        logic addr_null;
        logic free_bad_early;
        logic div_done;
        logic free_bad_late;
        logic create_last;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/sap_ram.sv
`timescale 1ns / 1ps

module sap_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/sap_div.sv
`timescale 1ns / 1ps

module sap_div
    import sap_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_diff;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/sap_ctrl.sv
`timescale 1ns / 1ps

module sap_ctrl
    import sap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.dirty)
                begin
                    cmd.div_start_n = 1'b1;
                    state_next      = ST_NWAIT;
                end
                else
                begin
                    in_stall = 1'b0;
                    if (in_valid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_NWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.load_n = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DECODE:
            begin
                if (!sts.op_free)
                begin
                    if (sts.any_found)
                    begin
                        cmd.sel_found = 1'b1;
                        state_next    = ST_POP_RD;
                    end
                    else if (!sts.pool_full)
                    begin
                        cmd.start_create = 1'b1;
                        state_next       = ST_CREATE;
                    end
                    else
                    begin
                        cmd.set_exhausted = 1'b1;
                        state_next        = ST_DONE;
                    end
                end
                else if (sts.addr_null)
                begin
                    cmd.set_null = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (sts.free_bad_early)
                begin
                    cmd.set_outside = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.div_start_free = 1'b1;
                    state_next         = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (sts.div_done)
                begin
                    if (sts.free_bad_late)
                    begin
                        cmd.set_outside = 1'b1;
                    end
                    else
                    begin
                        cmd.free_commit   = 1'b1;
                        cmd.set_done_zero = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_CREATE:
            begin
                cmd.create_step = 1'b1;
                if (sts.create_last)
                begin
                    cmd.create_finish = 1'b1;
                    state_next        = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_read = 1'b1;
                state_next   = ST_POP_UPD;
            end
            ST_POP_UPD:
            begin
                cmd.pop_update = 1'b1;
                state_next     = ST_POP_ADDR;
            end
            ST_POP_ADDR:
            begin
                cmd.pop_addr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sap_datapath.sv
`timescale 1ns / 1ps

module sap_datapath
    import sap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        operation,
    input  logic [31:0] object_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic [1:0]  status,
    input  cmd_t        cmd,
    output sts_t        sts
);

    // Configuration and derived slot count
    logic [10:0]            size_req_reg;
    logic [19:0]            pfp_reg;
    logic                   dirty_reg;
    logic [SLOT_W-1:0]      n_reg;
    logic [SIZE_W-1:0]      size_up;
    logic [SIZE_W-1:0]      eff_size;

    // Captured transaction
    logic                   op_reg;
    logic [31:0]            addr_reg;

    // Page bookkeeping
    logic [PAGES_CNT_W-1:0] pages_reg;
    logic [POOL_PAGES-1:0]  nz_reg;
    logic [LINK_W-1:0]      head_arr [POOL_PAGES];
    logic [CNT_W-1:0]       cnt_arr  [POOL_PAGES];
    logic [PAGE_W-1:0]      page_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [PROD_W-1:0]      prod_reg;

    // Result staging and output register
    logic [31:0]            res_stage_reg;
    logic [1:0]             status_stage_reg;
    logic                   out_valid_reg;
    logic [31:0]            out_addr_reg;
    logic [1:0]             out_status_reg;

    logic [POOL_PAGES-1:0]  live_mask;
    logic [POOL_PAGES-1:0]  cand;
    logic [PAGE_W-1:0]      found_page;
    logic [19:0]            free_page;
    logic [11:0]            offset;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       div_q;
    logic [DIV_W-1:0]       div_r;
    logic                   ram_we;
    logic [RAM_AW-1:0]      ram_waddr;
    logic [LINK_W-1:0]      ram_wdata;
    logic [LINK_W-1:0]      ram_rdata;
    logic [CNT_W-1:0]       cnt_cur;
    logic [CNT_W-1:0]       cnt_dec;
    logic [CNT_W-1:0]       cnt_inc;
    logic [SLOT_W:0]        slot_plus;
    logic [19:0]            page_num;

    // Effective object size: at least 8, rounded up to a multiple of 4.
    always_comb
    begin
        size_up = ({1'b0, size_req_reg} + 12'd3) & ~12'd3;
        if (size_req_reg < 11'd8)
        begin
            eff_size = 12'd8;
        end
        else
        begin
            eff_size = size_up;
        end
    end

    // Highest created page that still has a free slot.
    always_comb
    begin
        found_page = '0;
        for (int i = 0; i < POOL_PAGES; i++)
        begin
            live_mask[i] = (PAGES_CNT_W'(i) < pages_reg);
            cand[i]      = live_mask[i] & nz_reg[i];
            if (cand[i])
            begin
                found_page = PAGE_W'(i);
            end
        end
    end

    assign free_page = addr_reg[31:12] - pfp_reg;
    assign offset    = addr_reg[11:0];
    assign cnt_cur   = cnt_arr[page_reg];
    assign cnt_dec   = cnt_cur - CNT_W'(1);
    assign cnt_inc   = cnt_cur + CNT_W'(1);
    assign slot_plus = {1'b0, slot_reg} + (SLOT_W + 1)'(1);
    assign page_num  = pfp_reg + {16'd0, page_reg};

    // Shared divider: slot count per page, or slot index of a freed address.
    assign div_start    = cmd.div_start_n | cmd.div_start_free;
    assign div_dividend = cmd.div_start_n ? DIV_W'(PAGE_PAYLOAD)
                                          : (offset - 12'(HEADER_BYTES));

    sap_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_size),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Successor links: page creation chains slots, a free pushes one.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {page_reg, slot_reg};
        ram_wdata = '0;
        if (cmd.create_step)
        begin
            ram_we = 1'b1;
            if (!sts.create_last)
            begin
                ram_wdata = LINK_W'(slot_plus);
            end
        end
        else if (cmd.free_commit)
        begin
            ram_we    = 1'b1;
            ram_waddr = {page_reg, div_q[SLOT_W-1:0]};
            ram_wdata = head_arr[page_reg];
        end
    end

    sap_ram #(
        .WIDTH (LINK_W),
        .DEPTH (RAM_DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({page_reg, head_arr[page_reg][SLOT_W-1:0]}),
        .rdata (ram_rdata)
    );

    // Status towards the controller.
    always_comb
    begin
        sts.dirty          = dirty_reg;
        sts.op_free        = (op_reg == OP_FREE);
        sts.any_found      = |cand;
        sts.pool_full      = (pages_reg == PAGES_CNT_W'(POOL_PAGES));
        sts.addr_null      = (addr_reg == 32'd0);
        sts.free_bad_early = (free_page >= {15'd0, pages_reg})
                             || (offset < 12'(HEADER_BYTES));
        sts.div_done       = div_done;
        sts.free_bad_late  = (div_r != '0) || (div_q >= {3'd0, n_reg});
        sts.create_last    = (slot_plus == {1'b0, n_reg});
        sts.out_free       = !out_valid_reg || !out_stall;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_req_reg  <= 11'd32;
            pfp_reg       <= 20'd256;
            dirty_reg     <= 1'b1;
            pages_reg     <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_OBJECT_SIZE)
            begin
                size_req_reg <= cfg_data[10:0];
                dirty_reg    <= 1'b1;
            end
            else if (cmd.load_n)
            begin
                dirty_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == CFG_POOL_FIRST)
            begin
                pfp_reg <= cfg_data;
            end
            if (cmd.create_finish)
            begin
                pages_reg          <= pages_reg + PAGES_CNT_W'(1);
                nz_reg[page_reg]   <= 1'b1;
            end
            else if (cmd.pop_update)
            begin
                nz_reg[page_reg] <= (cnt_dec != '0);
            end
            else if (cmd.free_commit)
            begin
                nz_reg[page_reg] <= (cnt_inc != '0);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_n)
        begin
            n_reg <= div_q[SLOT_W-1:0];
        end
        if (cmd.accept)
        begin
            op_reg   <= operation;
            addr_reg <= object_address;
        end
        if (cmd.sel_found)
        begin
            page_reg <= found_page;
        end
        else if (cmd.start_create)
        begin
            page_reg <= pages_reg[PAGE_W-1:0];
        end
        else if (cmd.div_start_free)
        begin
            page_reg <= free_page[PAGE_W-1:0];
        end
        if (cmd.start_create)
        begin
            slot_reg <= '0;
        end
        else if (cmd.create_step)
        begin
            slot_reg <= slot_plus[SLOT_W-1:0];
        end
        else if (cmd.pop_read)
        begin
            slot_reg <= head_arr[page_reg][SLOT_W-1:0];
        end
        if (cmd.create_finish)
        begin
            head_arr[page_reg] <= '0;
            cnt_arr[page_reg]  <= {1'b0, n_reg};
        end
        else if (cmd.pop_update)
        begin
            head_arr[page_reg] <= {1'b0, ram_rdata[SLOT_W-1:0]};
            cnt_arr[page_reg]  <= cnt_dec;
        end
        else if (cmd.free_commit)
        begin
            head_arr[page_reg] <= {1'b0, div_q[SLOT_W-1:0]};
            cnt_arr[page_reg]  <= cnt_inc;
        end
        if (cmd.pop_update)
        begin
            prod_reg <= PROD_W'(slot_reg) * PROD_W'(eff_size);
        end
        if (cmd.pop_addr)
        begin
            res_stage_reg    <= {page_num, 12'd0} + 32'(HEADER_BYTES)
                                + {11'd0, prod_reg};
            status_stage_reg <= STATUS_DONE;
        end
        else if (cmd.set_exhausted)
        begin
            res_stage_reg    <= '0;
            status_stage_reg <= STATUS_EXHAUSTED;
        end
        else if (cmd.set_null)
        begin
            res_stage_reg    <= '0;
            status_stage_reg <= STATUS_NULL_FREE;
        end
        else if (cmd.set_outside)
        begin
            res_stage_reg    <= '0;
            status_stage_reg <= STATUS_OUTSIDE;
        end
        else if (cmd.set_done_zero)
        begin
            res_stage_reg    <= '0;
            status_stage_reg <= STATUS_DONE;
        end
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_stage_reg;
            out_status_reg <= status_stage_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

endmodule

FILE: sv/slab_object_allocator_core.sv
`timescale 1ns / 1ps
// Slab object allocator for one object size over a pool of sixteen 4 KiB pages.
// Input channel (in_valid, in_stall, operation, object_address): a transaction
// asks for an allocate or a free. Output channel (out_valid, out_stall,
// result_address, status): exactly one result per input transaction, in order.
// Configuration (cfg_we, cfg_index, cfg_data) sets the object size and the
// first pool page. The user must make writes only while the block is idle; the
// block itself does not enforce this. A null free, a free rejected on its page
// or header, or an exhausted allocate ends right after decode; any other free
// runs the 12-step slot divider, an allocate from an existing page pops the head
// slot, and one that creates a page first links its slots, one link per cycle.
// Throughput: one transaction at a time; a new one is taken once the previous
// result sits in the output register, so a stalled result does not block work.
// After reset, and after each object size write, the slots-per-page count is
// recomputed with in_stall held high.
// Reset empties the pool and restores the size to 32 and the first page to 256.
// While out_stall is high the result holds and the next result waits inside.

module slab_object_allocator_core
    import sap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] object_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer for each transaction.
    sap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Free lists, page table and result registers.
    sap_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .object_address (object_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
